// ===== sv/ids_pkg.sv =====
// shared types, codes and sizes for the integer deque with search
package ids_pkg;

    localparam int IDS_DEPTH = 64;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;

    localparam logic [2:0] ACT_INS_BACK  = 3'd0;
    localparam logic [2:0] ACT_INS_FRONT = 3'd1;
    localparam logic [2:0] ACT_DEL_BACK  = 3'd2;
    localparam logic [2:0] ACT_COUNT     = 3'd3;
    localparam logic [2:0] ACT_FIND      = 3'd4;
    localparam logic [2:0] ACT_MAX       = 3'd5;
    localparam logic [2:0] ACT_ODD       = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic [CNT_W-1:0]        entry_count;
        logic [POS_W-1:0]        position;
        logic                    has_prev;
        logic [POS_W-1:0]        prev_position;
        logic                    has_next;
        logic [POS_W-1:0]        next_position;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic start_scan;
        logic found;
        logic scan_end;
    } t_sts;

endpackage

// ===== sv/ids_ram.sv =====
// generic simple dual-port ram with registered read
module ids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ids_ctrl.sv =====
// controller state machine: accept, execute, scan and final result phases
module ids_ctrl import ids_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.start_scan) begin
                    n_state = S_SCAN;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_IDLE;
                end else if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== sv/ids_datapath.sv =====
// datapath: ring store, pointers, scan registers and output register
module ids_datapath import ids_pkg::*; #(
    parameter int DEPTH = IDS_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int SW = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SW:0]      DEPTH_W  = (SW+1)'(DEPTH);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(DEPTH - 1);

    logic [2:0]              r_action,   n_action;
    logic signed [VAL_W-1:0] r_value,    n_value;
    logic [SW-1:0]           r_front,    n_front;
    logic [CNT_W-1:0]        r_count,    n_count;
    logic [CNT_W-1:0]        r_iss_pos,  n_iss_pos;
    logic                    r_rd_vld,   n_rd_vld;
    logic [POS_W-1:0]        r_rd_pos,   n_rd_pos;
    logic [POS_W-1:0]        r_best_pos, n_best_pos;
    logic signed [VAL_W-1:0] r_best_val, n_best_val;
    logic                    r_pend_vld, n_pend_vld;
    logic [POS_W-1:0]        r_pend_pos, n_pend_pos;
    logic signed [VAL_W-1:0] r_pend_val, n_pend_val;
    logic                    r_out_vld;
    t_out                    r_out;

    logic                    ram_we;
    logic [SW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [SW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_q;
    logic signed [VAL_W-1:0] rd_val;

    logic       out_free, empty, full, is_scan, more, match, hold, found;
    logic       emit;
    t_out       res;
    logic [SW:0] rd_sum, bk_sum;
    logic [SW-1:0] rd_slot, bk_slot;

    ids_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign rd_val   = $signed(ram_q);
    assign out_free = !r_out_vld || !i_out_stall;
    assign empty    = (r_count == '0);
    assign full     = (r_count == FULL_CNT);
    assign is_scan  = (r_action == ACT_FIND) || (r_action == ACT_MAX) ||
                      (r_action == ACT_ODD);
    assign more     = (r_iss_pos < r_count);
    assign match    = r_rd_vld && (r_action == ACT_FIND) && (rd_val == r_value);

    // position to slot, wrapping once around the ring
    assign rd_sum  = {1'b0, r_front} + {1'b0, r_iss_pos[SW-1:0]};
    assign rd_slot = (rd_sum >= DEPTH_W) ? SW'(rd_sum - DEPTH_W) : rd_sum[SW-1:0];
    assign bk_sum  = {1'b0, r_front} + {1'b0, r_count[SW-1:0]};
    assign bk_slot = (bk_sum >= DEPTH_W) ? SW'(bk_sum - DEPTH_W) : bk_sum[SW-1:0];

    // a scan beat that has a result to give waits for the output register
    always_comb begin
        hold = 1'b0;
        if (i_cmd.scan && r_rd_vld && !out_free) begin
            if (r_action == ACT_FIND) begin
                hold = match;
            end else if (r_action == ACT_ODD) begin
                hold = ram_q[0] && r_pend_vld;
            end
        end
    end

    assign found = i_cmd.scan && (r_action == ACT_FIND) && match && out_free;

    always_comb begin
        n_action   = r_action;
        n_value    = r_value;
        n_front    = r_front;
        n_count    = r_count;
        n_iss_pos  = r_iss_pos;
        n_rd_vld   = r_rd_vld;
        n_rd_pos   = r_rd_pos;
        n_best_pos = r_best_pos;
        n_best_val = r_best_val;
        n_pend_vld = r_pend_vld;
        n_pend_pos = r_pend_pos;
        n_pend_val = r_pend_val;
        ram_we     = 1'b0;
        ram_waddr  = bk_slot;
        ram_wdata  = r_value;
        ram_re     = 1'b0;
        ram_raddr  = rd_slot;
        emit       = 1'b0;
        res        = '0;
        res.entry_count = r_count;
        res.last   = 1'b1;

        if (i_cmd.load) begin
            n_action = i_in_data.action;
            n_value  = i_in_data.value;
        end

        if (i_cmd.exec) begin
            case (r_action)
                ACT_INS_BACK, ACT_INS_FRONT: begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (full) begin
                            res.status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + 1'b1;
                            res.entry_count = r_count + 1'b1;
                            if (r_action == ACT_INS_FRONT) begin
                                n_front   = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
                                ram_waddr = n_front;
                            end
                        end
                    end
                end
                ACT_DEL_BACK: begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (empty) begin
                            res.status = ST_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                            res.entry_count = r_count - 1'b1;
                        end
                    end
                end
                ACT_FIND, ACT_MAX, ACT_ODD: begin
                    if (empty) begin
                        if (out_free) begin
                            emit = 1'b1;
                            res.status = (r_action == ACT_MAX) ? ST_EMPTY : ST_NOT_FOUND;
                        end
                    end else begin
                        n_iss_pos  = '0;
                        n_rd_vld   = 1'b0;
                        n_pend_vld = 1'b0;
                    end
                end
                default: begin
                    emit = out_free;
                end
            endcase
        end

        if (i_cmd.scan && !hold) begin
            if (more && !match) begin
                ram_re    = 1'b1;
                n_iss_pos = r_iss_pos + 1'b1;
                n_rd_pos  = r_iss_pos[POS_W-1:0];
                n_rd_vld  = 1'b1;
            end else begin
                n_rd_vld  = 1'b0;
            end
            if (r_rd_vld) begin
                case (r_action)
                    ACT_FIND: begin
                        if (match) begin
                            emit              = 1'b1;
                            res.position      = r_rd_pos;
                            res.has_prev      = (r_rd_pos != '0);
                            res.prev_position = (r_rd_pos != '0) ? r_rd_pos - 1'b1 : '0;
                            res.has_next      = ({1'b0, r_rd_pos} + 1'b1) < r_count;
                            res.next_position = (({1'b0, r_rd_pos} + 1'b1) < r_count) ?
                                                r_rd_pos + 1'b1 : '0;
                            res.entry_value   = rd_val;
                        end
                    end
                    ACT_MAX: begin
                        if ((r_rd_pos == '0) || (rd_val > r_best_val)) begin
                            n_best_pos = r_rd_pos;
                            n_best_val = rd_val;
                        end
                    end
                    ACT_ODD: begin
                        if (ram_q[0]) begin
                            if (r_pend_vld) begin
                                emit            = 1'b1;
                                res.position    = r_pend_pos;
                                res.entry_value = r_pend_val;
                                res.last        = 1'b0;
                            end
                            n_pend_vld = 1'b1;
                            n_pend_pos = r_rd_pos;
                            n_pend_val = rd_val;
                        end
                    end
                    default: begin
                        n_rd_vld = 1'b0;
                    end
                endcase
            end
        end

        if (i_cmd.done && out_free) begin
            emit = 1'b1;
            case (r_action)
                ACT_MAX: begin
                    res.position    = r_best_pos;
                    res.entry_value = r_best_val;
                end
                ACT_ODD: begin
                    if (r_pend_vld) begin
                        res.position    = r_pend_pos;
                        res.entry_value = r_pend_val;
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    res.status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_count    <= n_count;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_value    <= n_value;
        r_iss_pos  <= n_iss_pos;
        r_rd_pos   <= n_rd_pos;
        r_best_pos <= n_best_pos;
        r_best_val <= n_best_val;
        r_pend_pos <= n_pend_pos;
        r_pend_val <= n_pend_val;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.start_scan = is_scan && !empty;
    assign o_sts.found      = found;
    assign o_sts.scan_end   = !r_rd_vld && !more;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== sv/integer_deque_with_search_top.sv =====
// top level of the integer deque with search: controller and datapath
// Bounded deque of signed 32-bit values kept in a ring of DEPTH slots in one
// simple dual-port ram. One action is taken at a time: an action beat is taken
// only while the block is idle. Insert, delete, count or any action on an
// empty list is executed from the registered action and gives its single
// result through the output register. Search, maximum and odd listing walk
// the stored entries through the single ram read port, one read per cycle,
// and the next action beat is taken only once the walk and its result are
// through; a search ends early at its first match, and a search or an odd
// listing pauses while a pending result cannot enter the output register.
// The odd listing gives one result beat per odd entry, the final one with
// last set, or a single not-found beat when there is none. The store needs
// no clearing after reset: only positions below the count are read.
module integer_deque_with_search_top import ids_pkg::*; #(
    parameter int DEPTH = IDS_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    ids_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ids_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
